// File: rtl/prce_pkg.sv
// ----------------------------------------------------------------------------
// prce_pkg: shared types and constants of the palette range coder encoder.
// Holds the channel payload structs, the mode codes and the default sizes.
// ----------------------------------------------------------------------------
package prce_pkg;

  localparam int MAX_SYMBOLS_DEF   = 256;
  localparam int PENDING_LIMIT_DEF = 255;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] range_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic       color_missing;
    logic       pending_overflow;
  } out_item_t;

  // Table read or write request from the coder to the table memory.
  typedef struct packed {
    logic       wr;
    logic [7:0] addr;
    logic [23:0] color;
    logic [7:0] start;
  } tbl_req_t;

endpackage

// File: rtl/palette_range_coder_encoder_unit.sv
// ----------------------------------------------------------------------------
// palette_range_coder_encoder_unit: 16-bit arithmetic coder core.
// An encode scans the table up to the matched index (the repeat index for an
// unmatched colour), then shifts out the coded bits, flushes the pending bits
// and takes the underflow steps. One item is worked at a time; output stalls
// can hold it.
// Reset is synchronous, active low; the table memory is not cleared.
// ----------------------------------------------------------------------------
module palette_range_coder_encoder_unit #(
  parameter int MAX_SYMBOLS   = prce_pkg::MAX_SYMBOLS_DEF,
  parameter int PENDING_LIMIT = prce_pkg::PENDING_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prce_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prce_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data
);
  import prce_pkg::*;

  // The sequencer states. Scanning reads the table one entry a cycle; the
  // range states fetch the chosen entry's start and end and narrow the
  // interval; the precheck works out the overflow flag of the item before any
  // byte leaves; the bit states shift out one coded bit per cycle when not blocked.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,
    S_RS   = 9'b000000100,
    S_RE   = 9'b000001000,
    S_PRE  = 9'b000010000,
    S_NORM = 9'b000100000,
    S_PEND = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  count_r;          // effective symbol count minus one (repeat index)
  logic [15:0] low_r, low_nxt, high_r, high_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [7:0]  buf_r, buf_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [7:0]  idx_r, idx_nxt;   // scan index, then chosen symbol
  logic [23:0] color_r, color_nxt;
  logic        miss_r, miss_nxt, ovf_r, ovf_nxt;
  logic [7:0]  s_r, s_nxt;
  logic [16:0] width_r, width_nxt;
  logic        bit_r, bit_nxt;   // value of the pending bits being flushed
  logic [7:0]  hold_r, hold_nxt; // last completed byte, held until its last flag is known
  logic        hold_v_r, hold_v_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_v_r, out_v_nxt;
  tbl_req_t    req;
  logic [23:0] rd_color;
  logic [7:0]  rd_start;
  logic [8:0]  cnt_eff;
  logic [8:0]  e_w;
  logic [25:0] prod_s, prod_e;
  logic [15:0] eq_w, la_w, ha_w;
  logic [4:0]  lead_w;
  logic [14:0] und_w;
  logic [3:0]  k_w;
  logic [7:0]  pst_w;
  logic        pre_ovf;
  logic        out_free, blocked;
  logic        put_req, put_val, put_flush, put_full;
  logic [7:0]  sel_w, nb_w;

  prce_table #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_table (
    .clk(clk), .req(req), .rd_color(rd_color), .rd_start(rd_start)
  );

  // Clamp the written count to the supported range.
  always_comb begin
    cnt_eff = {1'b0, cfg_data};
    if (cnt_eff < 9'd2) cnt_eff = 9'd2;
    if (32'(cnt_eff) > MAX_SYMBOLS) cnt_eff = 9'(MAX_SYMBOLS);
  end

  // Overflow precheck on the narrowed interval. The shift loop moves out the
  // leading bits on which low and high agree; the underflow loop then runs
  // while low shows a one and high a zero just below the differing top bit.
  // The pending count saturates if the steps would carry it past the limit,
  // so the flag is known before the first byte of the item is sent.
  always_comb begin
    eq_w   = ~(low_r ^ high_r);
    lead_w = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (!eq_w[i]) lead_w = 5'(15 - i);
    end
    la_w  = low_r << lead_w;
    ha_w  = ~((~high_r) << lead_w);
    und_w = la_w[14:0] & ~ha_w[14:0];
    k_w   = 4'd15;
    for (int i = 0; i < 15; i++) begin
      if (!und_w[i]) k_w = 4'(14 - i);
    end
    if (la_w[15] || !ha_w[15]) k_w = 4'd0;
    // Any shifted bit flushes the pending bits first.
    pst_w   = (lead_w != 5'd0) ? 8'd0 : pend_r;
    pre_ovf = (32'(pst_w) + 32'(k_w)) > PENDING_LIMIT;
  end

  always_comb begin
    state_nxt = state_r; low_nxt = low_r; high_nxt = high_r; pend_nxt = pend_r;
    prev_nxt = prev_r; buf_nxt = buf_r; fill_nxt = fill_r; idx_nxt = idx_r;
    color_nxt = color_r; miss_nxt = miss_r; ovf_nxt = ovf_r; s_nxt = s_r;
    width_nxt = width_r; bit_nxt = bit_r; hold_nxt = hold_r; hold_v_nxt = hold_v_r;
    out_nxt = out_r;
    out_v_nxt = out_v_r && !out_ready;
    out_free  = !out_v_r || out_ready;
    // A completed byte can only enter the holding register when the byte
    // already held there can move on to the output register.
    blocked   = hold_v_r && !out_free;
    req = '{wr: 1'b0, addr: idx_r, color: {in_data.red, in_data.green, in_data.blue},
            start: in_data.range_start};
    in_ready  = (state_r == S_IDLE);
    put_req = 1'b0; put_val = 1'b0; put_flush = 1'b0;
    put_full = (fill_r == 3'd7);
    sel_w = idx_r;
    nb_w  = buf_r;
    // The repeat entry's range ends at the top of the scale.
    e_w    = (idx_r == count_r) ? 9'd256 : {1'b0, rd_start};
    prod_s = 26'(width_r) * 26'(s_r);
    prod_e = 26'(width_r) * 26'(e_w);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          miss_nxt = 1'b0; ovf_nxt = 1'b0; color_nxt = req.color;
          case (in_data.mode)
            MODE_LOAD: begin
              req.wr = 1'b1; req.addr = in_data.entry_index;
              state_nxt = S_DONE;
            end
            MODE_ENCODE: begin
              idx_nxt = 8'd0; req.addr = 8'd0;
              state_nxt = S_SCAN;
            end
            MODE_FINISH: state_nxt = S_FIN;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        // rd_color holds entry idx_r. The repeat entry's colour is never
        // compared: reaching it means the colour is missing.
        if (idx_r == count_r || rd_color == color_r) begin
          if (idx_r == count_r) miss_nxt = 1'b1;
          if (idx_r == prev_r) sel_w = count_r;
          else begin
            sel_w = idx_r; prev_nxt = idx_r;
          end
          idx_nxt = sel_w; req.addr = sel_w;
          state_nxt = S_RS;
        end else begin
          idx_nxt = idx_r + 8'd1; req.addr = idx_r + 8'd1;
        end
      end
      S_RS: begin
        s_nxt     = rd_start;
        width_nxt = 17'(high_r) - 17'(low_r) + 17'd1;
        req.addr  = idx_r + 8'd1;
        state_nxt = S_RE;
      end
      S_RE: begin
        high_nxt  = low_r + prod_e[23:8] - 16'd1;
        low_nxt   = low_r + prod_s[23:8];
        state_nxt = S_PRE;
      end
      S_PRE: begin
        ovf_nxt   = pre_ovf;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (low_r[15] == high_r[15]) begin
          if (!(put_full && blocked)) begin
            put_req = 1'b1; put_val = low_r[15]; bit_nxt = ~low_r[15];
            low_nxt = {low_r[14:0], 1'b0}; high_nxt = {high_r[14:0], 1'b1};
            if (pend_r != 8'd0) state_nxt = S_PEND;
          end
        end else if (low_r[15:14] == 2'b01 && high_r[15:14] == 2'b10) begin
          if (32'(pend_r) < PENDING_LIMIT) pend_nxt = pend_r + 8'd1;
          low_nxt  = {low_r[14:0], 1'b0} ^ 16'h8000;
          high_nxt = {high_r[14:0], 1'b0} ^ 16'h8001;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PEND: begin
        if (!(put_full && blocked)) begin
          put_req = 1'b1; put_val = bit_r; pend_nxt = pend_r - 8'd1;
          if (pend_r == 8'd1) state_nxt = S_NORM;
        end
      end
      S_FIN: begin
        // The closing one bit and the zero padding complete the byte at once.
        if (!blocked) begin
          put_req = 1'b1; put_val = 1'b1; put_flush = 1'b1;
          low_nxt = 16'h0000; high_nxt = 16'hffff; pend_nxt = 8'd0;
          prev_nxt = count_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Final item: the held byte with the last flag, or an empty marker.
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_nxt = '{out_byte: hold_v_r ? hold_r : 8'd0, has_byte: hold_v_r,
                      last: 1'b1, color_missing: miss_r, pending_overflow: ovf_r};
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Bit packing, LSB first. A completed byte goes to the holding register;
    // the byte held before it is sent on as an item that is not the last.
    if (put_req) begin
      nb_w = buf_r | (8'(put_val) << fill_r);
      if (put_full || put_flush) begin
        buf_nxt = 8'd0; fill_nxt = 3'd0;
        hold_nxt = nb_w; hold_v_nxt = 1'b1;
        if (hold_v_r) begin
          out_v_nxt = 1'b1;
          out_nxt = '{out_byte: hold_r, has_byte: 1'b1, last: 1'b0,
                      color_missing: miss_r, pending_overflow: ovf_r};
        end
      end else begin
        buf_nxt = nb_w; fill_nxt = fill_r + 3'd1;
      end
    end

    if (cfg_we) prev_nxt = 8'(cnt_eff - 9'd1);
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= 8'd1; low_r <= 16'h0000; high_r <= 16'hffff;
      pend_r <= 8'd0; prev_r <= 8'd1; buf_r <= 8'd0; fill_r <= 3'd0;
      hold_v_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; low_r <= low_nxt; high_r <= high_nxt;
      pend_r <= pend_nxt; prev_r <= prev_nxt; buf_r <= buf_nxt; fill_r <= fill_nxt;
      hold_v_r <= hold_v_nxt; out_v_r <= out_v_nxt;
      if (cfg_we) count_r <= 8'(cnt_eff - 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; color_r <= color_nxt; miss_r <= miss_nxt; ovf_r <= ovf_nxt;
    s_r <= s_nxt; width_r <= width_nxt; bit_r <= bit_nxt; hold_r <= hold_nxt;
    out_r <= out_nxt;
  end
endmodule

// File: rtl/prce_table.sv
// ----------------------------------------------------------------------------
// prce_table: symbol table memory.
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module prce_table #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic              clk,
  input  prce_pkg::tbl_req_t req,
  output logic [23:0]       rd_color,
  output logic [7:0]        rd_start
);
  import prce_pkg::*;

  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  logic [31:0] mem [MAX_SYMBOLS];
  logic [31:0] rd_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      if (32'(req.addr) < MAX_SYMBOLS) begin
        mem[req.addr[AW-1:0]] <= {req.color, req.start};
      end
    end else begin
      rd_r <= mem[req.addr[AW-1:0]];
    end
  end

  assign rd_color = rd_r[31:8];
  assign rd_start = rd_r[7:0];
endmodule
